// ===== rtl/core/segment_packing_ring_queue_defines.svh =====
// Assertion macros for the segment ring queue.
// Taken in by the top level only; needs nothing else.
`ifndef SEGMENT_PACKING_RING_QUEUE_DEFINES_SVH
`define SEGMENT_PACKING_RING_QUEUE_DEFINES_SVH

// same-cycle implication, off during reset
`define SPRQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define SPRQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/sprq_pkg.sv =====
// Shared constants and controller/datapath interface types for the segment ring queue.
// No dependencies.
`default_nettype none

package sprq_pkg;

  localparam int FILL_W = 16;
  localparam int PEND_W = 16;
  localparam int WORD_W = FILL_W + PEND_W;

  localparam int          HEADER_BYTES = 4;
  localparam logic [15:0] PAD_MASK     = 16'hFFFC;

  localparam logic [2:0] CMD_ACQUIRE = 3'd0;
  localparam logic [2:0] CMD_COMMIT  = 3'd1;
  localparam logic [2:0] CMD_POP     = 3'd2;
  localparam logic [2:0] CMD_RELEASE = 3'd3;
  localparam logic [2:0] CMD_CLEAR   = 3'd4;

  localparam logic [1:0] CFG_MAX_PACKET   = 2'd0;
  localparam logic [1:0] CFG_SEG_CAPACITY = 2'd1;

  localparam logic [15:0] MAX_PACKET_RESET   = 16'd1024;
  localparam logic [15:0] SEG_CAPACITY_RESET = 16'd1472;

  // controller -> datapath
  typedef struct packed {
    logic latch;      // take the command fields
    logic init_step;  // zero one table entry
    logic open_rd;    // read the open segment entry
    logic sid_rd;     // read the committed segment entry
    logic pop_rd;     // read the head entry, hand over the lost count
    logic acq_upd;
    logic com_upd;
    logic fl_upd;
    logic pop_upd;
    logic rel;
    logic empty;
    logic finish;     // load the result register
  } sprq_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic init_last;
    logic size_ok;
    logic flush;
    logic used_zero;
    logic rsp_free;
  } sprq_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/segment_packing_ring_queue.sv =====
// Top level of the segment ring queue: sequencer, datapath and port assertions.
// Uses sprq_pkg, sprq_ctrl, sprq_datapath and segment_packing_ring_queue_defines.svh.
`default_nettype none

// Keeps the books for a ring of SEGMENTS transmit segments: acquire places a padded
// message plus its 4-byte header in the open segment, commit lowers a segment's
// pending count, pop hands over the lost count and offers a complete head segment,
// release frees the head and clear empties the ring. Every command gives exactly
// one result. After reset the segment table is zeroed one entry a cycle, and no
// command is taken until every entry is zeroed; configuration writes are taken
// at any time. A command then holds the block until its result is issued: acquire,
// pop and commit pass a read state and an update state, commit with flush a second
// pair for the open segment, refused acquires and pops on an empty ring the read
// state only, and release, clear and unknown codes neither; release and clear have
// a state of their own. The segment table is a one-read-port RAM with registered
// data, and the level is read back from the open segment before the result is issued. A
// finished result waits in its output register while the next command is
// accepted; a command that finishes while that register still holds an untaken
// result stalls in its last cycle until the result is taken.

`include "segment_packing_ring_queue_defines.svh"

module segment_packing_ring_queue
  import sprq_pkg::*;
#(
  parameter int SEGMENTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // command
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  logic [2:0]  cmd,
  input  logic [15:0] packet_bytes,
  input  logic [3:0]  segment_id,
  input  logic        flush,
  // response
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic        ok,
  output logic [3:0]  slot,
  output logic [15:0] byte_offset,
  output logic [15:0] byte_count,
  output logic [31:0] lost_count,
  output logic [4:0]  level
);

  sprq_ctl_t  ctl;
  sprq_stat_t st;

  assign cfg_ready = 1'b1;

  sprq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready),
    .st        (st),
    .ctl       (ctl)
  );

  sprq_datapath #(
    .SEGMENTS (SEGMENTS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .st           (st),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .packet_bytes (packet_bytes),
    .segment_id   (segment_id),
    .flush        (flush),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .ok           (ok),
    .slot         (slot),
    .byte_offset  (byte_offset),
    .byte_count   (byte_count),
    .lost_count   (lost_count),
    .level        (level)
  );

  // one command in flight at a time
  `SPRQ_ASSERT_NEXT(a_single_cmd, clk, rst, cmd_valid && cmd_ready, !cmd_ready, "command taken while busy")

  // a finished command always lands in the response register
  `SPRQ_ASSERT_NEXT(a_finish_rsp, clk, rst, ctl.finish, rsp_valid, "finished command gave no response")

  // a granted acquire or a ready pop never reports an empty size
  `SPRQ_ASSERT_SAME(a_ok_count, clk, rst, rsp_valid && ok, byte_count != 16'd0, "ok with zero byte count")

endmodule

`default_nettype wire

// ===== rtl/core/sprq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module sprq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sprq_ctrl.sv =====
// Command sequencer for the segment ring queue.
// Uses sprq_pkg; drives sprq_datapath through sprq_ctl_t and reads sprq_stat_t back.
`default_nettype none

module sprq_ctrl
  import sprq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  input  logic [2:0] cmd,
  output logic       cmd_ready,
  input  sprq_stat_t st,
  output sprq_ctl_t  ctl
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE,
    S_ACQ_RD, S_ACQ_UPD,
    S_COM_RD, S_COM_UPD, S_FL_RD, S_FL_UPD,
    S_POP_RD, S_POP_UPD,
    S_REL, S_EMPTY,
    S_LVL_RD, S_FINISH
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign cmd_ready = (state == S_IDLE);

  always_comb begin
    ctl        = '0;
    state_next = state;
    unique case (state)
      S_INIT: begin
        ctl.init_step = 1'b1;
        if (st.init_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (cmd_valid) begin
          ctl.latch = 1'b1;
          unique case (cmd)
            CMD_ACQUIRE: state_next = S_ACQ_RD;
            CMD_COMMIT:  state_next = S_COM_RD;
            CMD_POP:     state_next = S_POP_RD;
            CMD_RELEASE: state_next = S_REL;
            CMD_CLEAR:   state_next = S_EMPTY;
            default:     state_next = S_LVL_RD;
          endcase
        end
      end
      S_ACQ_RD: begin
        ctl.open_rd = 1'b1;
        state_next  = st.size_ok ? S_ACQ_UPD : S_LVL_RD;
      end
      S_ACQ_UPD: begin
        ctl.acq_upd = 1'b1;
        state_next  = S_LVL_RD;
      end
      S_COM_RD: begin
        ctl.sid_rd = 1'b1;
        state_next = S_COM_UPD;
      end
      S_COM_UPD: begin
        ctl.com_upd = 1'b1;
        state_next  = st.flush ? S_FL_RD : S_LVL_RD;
      end
      S_FL_RD: begin
        ctl.open_rd = 1'b1;
        state_next  = S_FL_UPD;
      end
      S_FL_UPD: begin
        ctl.fl_upd = 1'b1;
        state_next = S_LVL_RD;
      end
      S_POP_RD: begin
        ctl.pop_rd = 1'b1;
        state_next = st.used_zero ? S_LVL_RD : S_POP_UPD;
      end
      S_POP_UPD: begin
        ctl.pop_upd = 1'b1;
        state_next  = S_LVL_RD;
      end
      S_REL: begin
        ctl.rel    = 1'b1;
        state_next = S_LVL_RD;
      end
      S_EMPTY: begin
        ctl.empty  = 1'b1;
        state_next = S_LVL_RD;
      end
      S_LVL_RD: begin
        ctl.open_rd = 1'b1;
        state_next  = S_FINISH;
      end
      S_FINISH: begin
        // hold here while the previous result is still waiting
        if (st.rsp_free) begin
          ctl.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/sprq_datapath.sv =====
// Ring pointers, segment table, lost counter, config and result registers.
// Uses sprq_pkg and sprq_ram; steered by sprq_ctrl.
`default_nettype none

module sprq_datapath
  import sprq_pkg::*;
#(
  parameter int SEGMENTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  sprq_ctl_t   ctl,
  output sprq_stat_t  st,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic [15:0] packet_bytes,
  input  logic [3:0]  segment_id,
  input  logic        flush,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic        ok,
  output logic [3:0]  slot,
  output logic [15:0] byte_offset,
  output logic [15:0] byte_count,
  output logic [31:0] lost_count,
  output logic [4:0]  level
);

  localparam int IW = $clog2(SEGMENTS);
  localparam int UW = $clog2(SEGMENTS + 1);
  localparam logic [IW:0]   SEG_WRAP = (IW + 1)'(SEGMENTS);
  localparam logic [UW-1:0] SEG_FULL = UW'(SEGMENTS);
  localparam logic [IW-1:0] SEG_LAST = IW'(SEGMENTS - 1);

  // config
  logic [15:0] max_packet, seg_capacity;
  // latched command fields
  logic [15:0] pkt_q;
  logic [3:0]  sid_q;
  logic        flush_q;
  // ring state
  logic [IW-1:0] head;
  logic [UW-1:0] used;
  logic          open_valid;
  logic [31:0]   lost;
  logic [IW-1:0] init_addr;
  // result being built
  logic          res_ok;
  logic [IW-1:0] res_slot;
  logic [15:0]   res_off, res_cnt;
  logic [31:0]   res_lost;

  // table port
  logic              we, re;
  logic [IW-1:0]     waddr, raddr;
  logic [WORD_W-1:0] wdata, rdata;
  logic [FILL_W-1:0] rd_fill;
  logic [PEND_W-1:0] rd_pend;

  logic [IW-1:0] open_slot, next_slot, sid_addr;
  logic [IW+3:0] sid_ext, slot_ext;
  logic          sid_valid, ring_full;
  logic [16:0]   pad_sum, padded;
  logic [17:0]   msg;
  logic          size_ok, acq_overflow, fl_open, pop_open, pop_ready, open_go;
  logic [UW-1:0] pop_used, lvl_used;
  logic [UW+4:0] lvl_ext;

  function automatic logic [IW-1:0] ring_at(input logic [IW-1:0] h,
                                             input logic [IW-1:0] off);
    logic [IW:0] sum;
    sum = {1'b0, h} + {1'b0, off};
    if (sum >= SEG_WRAP) sum = sum - SEG_WRAP;
    return sum[IW-1:0];
  endfunction

  sprq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SEGMENTS)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_fill = rdata[WORD_W-1:PEND_W];
  assign rd_pend = rdata[PEND_W-1:0];

  always_comb begin
    open_slot = (used == '0) ? head : ring_at(head, IW'(used - UW'(1)));
    next_slot = ring_at(head, IW'(used));
    ring_full = (used >= SEG_FULL);

    sid_ext   = {{IW{1'b0}}, sid_q};
    sid_addr  = sid_ext[IW-1:0];
    sid_valid = (sid_ext < (IW + 4)'(SEGMENTS));

    // pad to a word multiple, then add the header
    pad_sum = {1'b0, pkt_q} + 17'd3;
    padded  = {pad_sum[16], pad_sum[15:0] & PAD_MASK};
    msg     = {1'b0, padded} + 18'(HEADER_BYTES);
    size_ok = (pkt_q != '0) && (pkt_q <= max_packet) && (msg <= {2'b00, seg_capacity});

    acq_overflow = !open_valid || (({2'b00, rd_fill} + msg) > {2'b00, seg_capacity});
    fl_open      = open_valid && (rd_fill != '0);
    pop_open     = (used == UW'(1)) && (rd_fill != '0) && flush_q;
    pop_used     = (pop_open && !ring_full) ? used + UW'(1) : used;
    pop_ready    = (pop_used > UW'(1)) && (rd_pend == '0) && (rd_fill != '0);

    open_go = (ctl.acq_upd && acq_overflow) || (ctl.fl_upd && fl_open) ||
              (ctl.pop_upd && pop_open);

    if (used > UW'(1)) begin
      lvl_used = used;
    end else if ((used == UW'(1)) && open_valid && (rd_fill != '0)) begin
      lvl_used = UW'(1);
    end else begin
      lvl_used = '0;
    end
    lvl_ext  = {5'b0, lvl_used};
    slot_ext = {4'b0, res_slot};
  end

  always_comb begin
    re    = ctl.open_rd | ctl.sid_rd | ctl.pop_rd;
    raddr = ctl.sid_rd ? sid_addr : (ctl.pop_rd ? head : open_slot);

    we    = 1'b0;
    waddr = init_addr;
    wdata = '0;
    if (ctl.init_step) begin
      we = 1'b1;
    end else if (open_go) begin
      // a freshly opened segment starts empty, or with this message in it
      we    = !ring_full;
      waddr = next_slot;
      wdata = ctl.acq_upd ? {FILL_W'(msg), PEND_W'(1)} : '0;
    end else if (ctl.acq_upd) begin
      we    = 1'b1;
      waddr = open_slot;
      wdata = {rd_fill + FILL_W'(msg), rd_pend + PEND_W'(1)};
    end else if (ctl.com_upd) begin
      we    = sid_valid && (rd_pend != '0);
      waddr = sid_addr;
      wdata = {rd_fill, rd_pend - PEND_W'(1)};
    end
  end

  assign st.init_last = (init_addr == SEG_LAST);
  assign st.size_ok   = size_ok;
  assign st.flush     = flush_q;
  assign st.used_zero = (used == '0);
  assign st.rsp_free  = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_packet   <= MAX_PACKET_RESET;
      seg_capacity <= SEG_CAPACITY_RESET;
      head         <= '0;
      used         <= UW'(1);
      open_valid   <= 1'b1;
      lost         <= '0;
      init_addr    <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_MAX_PACKET:   max_packet   <= cfg_data;
          CFG_SEG_CAPACITY: seg_capacity <= cfg_data;
          default: ;
        endcase
      end
      if (ctl.init_step) init_addr <= init_addr + IW'(1);

      if (open_go) begin
        if (ring_full) begin
          open_valid <= 1'b0;
          // an acquire or a flushing commit can find the ring full here; only an acquire counts as lost
          if (ctl.acq_upd && (lost != '1)) lost <= lost + 32'd1;
        end else begin
          used       <= used + UW'(1);
          open_valid <= 1'b1;
        end
      end
      if (ctl.pop_rd) lost <= '0;

      if (ctl.rel && (used != '0)) begin
        if (used == UW'(1)) open_valid <= 1'b0;
        head <= (head == SEG_LAST) ? '0 : head + IW'(1);
        used <= used - UW'(1);
      end
      if (ctl.empty) begin
        head       <= '0;
        used       <= '0;
        open_valid <= 1'b0;
      end

      if (ctl.finish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      pkt_q    <= packet_bytes;
      sid_q    <= segment_id;
      flush_q  <= flush;
      res_ok   <= 1'b0;
      res_slot <= '0;
      res_off  <= '0;
      res_cnt  <= '0;
      res_lost <= '0;
    end
    if (ctl.acq_upd && !(acq_overflow && ring_full)) begin
      res_ok   <= 1'b1;
      res_slot <= acq_overflow ? next_slot : open_slot;
      res_off  <= acq_overflow ? 16'd0 : rd_fill;
      res_cnt  <= padded[15:0];
    end
    if (ctl.pop_rd) res_lost <= lost;
    if (ctl.pop_upd && pop_ready) begin
      res_ok   <= 1'b1;
      res_slot <= head;
      res_cnt  <= rd_fill;
    end
    if (ctl.finish) begin
      ok          <= res_ok;
      slot        <= slot_ext[3:0];
      byte_offset <= res_off;
      byte_count  <= res_cnt;
      lost_count  <= res_lost;
      level       <= lvl_ext[4:0];
    end
  end

endmodule

`default_nettype wire

// ===== sim/segment_queue_checker.sv =====
// Checker for the segment ring queue: watches the configuration, command and response
// channels, predicts each response and compares it field by field. Needs sprq_pkg.
`timescale 1ns / 1ps

module segment_queue_checker
  import sprq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        cmd_valid,
  input  logic        cmd_ready,
  input  logic [2:0]  cmd,
  input  logic [15:0] packet_bytes,
  input  logic [3:0]  segment_id,
  input  logic        flush,
  input  logic        rsp_valid,
  input  logic        rsp_ready,
  input  logic        ok,
  input  logic [3:0]  slot,
  input  logic [15:0] byte_offset,
  input  logic [15:0] byte_count,
  input  logic [31:0] lost_count,
  input  logic [4:0]  level,
  output int          fail_count,
  output int          waiting,
  output logic [3:0]  commit_hint
);

  localparam int RING_SLOTS = 16;

  typedef struct packed {
    logic        ok;
    logic [3:0]  slot;
    logic [15:0] offset;
    logic [15:0] count;
    logic [31:0] lost;
    logic [4:0]  level;
  } seg_result_t;

  seg_result_t expected_q[$];

  // predicted ring state and register copies
  logic [3:0]  head_q;
  logic [4:0]  used_q;
  logic        open_q;
  logic [15:0] fill_q [RING_SLOTS];
  logic [15:0] pend_q [RING_SLOTS];
  logic [31:0] lost_q;
  logic [15:0] max_pkt_q;
  logic [15:0] seg_cap_q;

  function automatic logic [3:0] ring_at(int unsigned ofs);
    return 4'(32'(head_q) + ofs);
  endfunction

  function automatic logic [3:0] open_slot();
    return (used_q == 0) ? head_q : ring_at(used_q - 1);
  endfunction

  function automatic void open_next();
    logic [3:0] s;
    if (used_q >= RING_SLOTS) begin
      open_q = 1'b0;
    end else begin
      s = ring_at(used_q);
      fill_q[s] = '0;
      pend_q[s] = '0;
      open_q = 1'b1;
      used_q = used_q + 1;
    end
  endfunction

  function automatic seg_result_t predict_result(logic [2:0] c, logic [15:0] pkt,
                                                 logic [3:0] sid, logic fl);
    seg_result_t r;
    logic [31:0] padded;
    logic [31:0] msg;
    logic [3:0]  s;
    r = '0;
    case (c)
      CMD_ACQUIRE: begin
        // padding keeps the carry above bit 15 so an oversize packet is refused
        padded = (32'(pkt) + 32'd3) & {16'h0003, PAD_MASK};
        msg = padded + HEADER_BYTES;
        if (pkt != 0 && pkt <= max_pkt_q && msg <= 32'(seg_cap_q)) begin
          if (!open_q || 32'(fill_q[open_slot()]) + msg > 32'(seg_cap_q))
            open_next();
          if (open_q) begin
            s = open_slot();
            r.offset = fill_q[s];
            fill_q[s] = fill_q[s] + msg[15:0];
            pend_q[s] = pend_q[s] + 16'd1;
            r.ok = 1'b1;
            r.slot = s;
            r.count = padded[15:0];
          end else if (lost_q != '1) begin
            lost_q = lost_q + 1;
          end
        end
      end
      CMD_COMMIT: begin
        if (pend_q[sid] != 0)
          pend_q[sid] = pend_q[sid] - 16'd1;
        if (fl && open_q && fill_q[open_slot()] != 0)
          open_next();
      end
      CMD_POP: begin
        r.lost = lost_q;
        lost_q = '0;
        if (used_q >= 1) begin
          s = head_q;
          if (used_q == 1 && fill_q[s] != 0 && fl)
            open_next();
          if (used_q > 1 && pend_q[s] == 0 && fill_q[s] != 0) begin
            r.ok = 1'b1;
            r.slot = s;
            r.count = fill_q[s];
          end
        end
      end
      CMD_RELEASE: begin
        if (used_q > 0) begin
          if (used_q == 1)
            open_q = 1'b0;
          head_q = head_q + 4'd1;
          used_q = used_q - 1;
        end
      end
      CMD_CLEAR: begin
        head_q = '0;
        used_q = '0;
        open_q = 1'b0;
      end
      default: ;
    endcase
    if (used_q > 1)
      r.level = used_q;
    else if (used_q == 1 && open_q && fill_q[open_slot()] != 0)
      r.level = 5'd1;
    else
      r.level = 5'd0;
    return r;
  endfunction

  always @(posedge clk) begin
    seg_result_t want;
    logic [3:0]  hint;
    if (rst) begin
      head_q = '0;
      used_q = 5'd1;
      open_q = 1'b1;
      for (int i = 0; i < RING_SLOTS; i++) begin
        fill_q[i] = '0;
        pend_q[i] = '0;
      end
      lost_q = '0;
      max_pkt_q = MAX_PACKET_RESET;
      seg_cap_q = SEG_CAPACITY_RESET;
      expected_q.delete();
      fail_count <= 0;
      waiting <= 0;
      commit_hint <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_MAX_PACKET)
          max_pkt_q = cfg_data;
        else if (cfg_index == CFG_SEG_CAPACITY)
          seg_cap_q = cfg_data;
      end
      // the response register may hand over an older result while a command is taken
      if (rsp_valid && rsp_ready) begin
        if (expected_q.size() == 0) begin
          $error("response transaction with no command outstanding");
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if ({ok, slot, byte_offset, byte_count, lost_count, level} !== want) begin
            fail_count <= fail_count + 1;
            if (ok !== want.ok)
              $error("ok: expected %0h, actual %0h", want.ok, ok);
            if (slot !== want.slot)
              $error("slot: expected %0h, actual %0h", want.slot, slot);
            if (byte_offset !== want.offset)
              $error("byte_offset: expected %0h, actual %0h", want.offset, byte_offset);
            if (byte_count !== want.count)
              $error("byte_count: expected %0h, actual %0h", want.count, byte_count);
            if (lost_count !== want.lost)
              $error("lost_count: expected %0h, actual %0h", want.lost, lost_count);
            if (level !== want.level)
              $error("level: expected %0h, actual %0h", want.level, level);
          end
        end
      end
      if (cmd_valid && cmd_ready) begin
        expected_q.push_back(predict_result(cmd, packet_bytes, segment_id, flush));
        // steer commits at the oldest held segment that still has messages pending
        hint = open_slot();
        for (int i = used_q - 1; i >= 0; i--)
          if (pend_q[ring_at(i)] != 0)
            hint = ring_at(i);
        commit_hint <= hint;
      end
      waiting <= expected_q.size();
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for segment_packing_ring_queue: clock, reset, stimulus and verdict.
// Needs sprq_pkg, the block itself and segment_queue_checker.
`timescale 1ns / 1ps

module tb_top
  import sprq_pkg::*;
();

  localparam logic [2:0] CMD_RSVD_LO = 3'd5;
  localparam logic [2:0] CMD_RSVD_HI = 3'd7;

  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 250;
  localparam int STALL_LIMIT  = 4000;

  // register settings per phase, extremes included
  localparam logic [15:0] MAX_TAB [PHASES] =
    '{16'd1024, 16'd1, 16'd65535, 16'd100, 16'd65535, 16'd12, 16'd2000, 16'd60};
  localparam logic [15:0] CAP_TAB [PHASES] =
    '{16'd1472, 16'd8, 16'd65535, 16'd300, 16'd8, 16'd65535, 16'd4096, 16'd64};

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        cmd_valid;
  logic        cmd_ready;
  logic [2:0]  cmd;
  logic [15:0] packet_bytes;
  logic [3:0]  segment_id;
  logic        flush;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  logic        ok;
  logic [3:0]  slot;
  logic [15:0] byte_offset;
  logic [15:0] byte_count;
  logic [31:0] lost_count;
  logic [4:0]  level;

  int         fail_count;
  int         waiting;
  logic [3:0] commit_hint;
  int         send_idle = 0;
  int         recv_idle = 0;
  int         stall_cycles = 0;
  logic [15:0] cur_max = MAX_PACKET_RESET;
  logic [15:0] cur_cap = SEG_CAPACITY_RESET;

  segment_packing_ring_queue dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd),
    .packet_bytes (packet_bytes),
    .segment_id   (segment_id),
    .flush        (flush),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .ok           (ok),
    .slot         (slot),
    .byte_offset  (byte_offset),
    .byte_count   (byte_count),
    .lost_count   (lost_count),
    .level        (level)
  );

  segment_queue_checker chk (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd),
    .packet_bytes (packet_bytes),
    .segment_id   (segment_id),
    .flush        (flush),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .ok           (ok),
    .slot         (slot),
    .byte_offset  (byte_offset),
    .byte_count   (byte_count),
    .lost_count   (lost_count),
    .level        (level),
    .fail_count   (fail_count),
    .waiting      (waiting),
    .commit_hint  (commit_hint)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(negedge clk)
    rsp_ready <= ($urandom_range(99) >= recv_idle);

  // watchdog: any transaction on any channel restarts the count
  always @(posedge clk) begin
    if ((cfg_valid && cfg_ready) || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance with valid
  // still high, so back-to-back commands need no lowering
  task automatic send_cmd(input logic [2:0] c, input logic [15:0] pkt,
                          input logic [3:0] sid, input logic fl);
    if ($urandom_range(99) < send_idle) begin
      cmd_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle);
    end
    cmd_valid    <= 1'b1;
    cmd          <= c;
    packet_bytes <= pkt;
    segment_id   <= sid;
    flush        <= fl;
    @(posedge clk);
    while (cmd_ready !== 1'b1) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    while (waiting != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    int          w;
    int          r;
    int          lim;
    int          small_lim;
    logic [2:0]  c;
    logic [15:0] pkt;
    logic [3:0]  sid;
    logic        fl;

    rst          = 1'b1;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    cmd_valid    = 1'b0;
    cmd          = CMD_ACQUIRE;
    packet_bytes = '0;
    segment_id   = '0;
    flush        = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle <= 6;
    recv_idle <= 88;

    // directed part under the reset register values
    send_cmd(CMD_POP, 16'd0, 4'd0, 1'b0);          // pop with only an empty open segment
    send_cmd(CMD_ACQUIRE, 16'd0, 4'd0, 1'b0);      // zero size refused
    send_cmd(CMD_ACQUIRE, 16'd1025, 4'd0, 1'b0);   // above maximum refused
    send_cmd(CMD_ACQUIRE, 16'd1024, 4'd0, 1'b0);
    send_cmd(CMD_ACQUIRE, 16'd1, 4'd0, 1'b0);
    send_cmd(CMD_ACQUIRE, 16'd3, 4'd0, 1'b0);
    send_cmd(CMD_ACQUIRE, 16'd1024, 4'd0, 1'b0);   // no room, next segment opens
    send_cmd(CMD_COMMIT, 16'd0, 4'd0, 1'b0);
    send_cmd(CMD_COMMIT, 16'd0, 4'd9, 1'b0);       // pending already zero
    send_cmd(CMD_POP, 16'd0, 4'd0, 1'b0);          // head still pending
    send_cmd(CMD_COMMIT, 16'd0, 4'd0, 1'b0);
    send_cmd(CMD_COMMIT, 16'd0, 4'd0, 1'b0);
    send_cmd(CMD_POP, 16'd0, 4'd0, 1'b0);          // head complete
    send_cmd(CMD_COMMIT, 16'd0, 4'd1, 1'b1);       // commit with flush
    send_cmd(CMD_RELEASE, 16'd0, 4'd0, 1'b0);
    send_cmd(CMD_POP, 16'd0, 4'd0, 1'b1);          // pop with flush; head complete, ring holds two segments
    send_cmd(CMD_RSVD_LO, 16'd0, 4'd0, 1'b0);
    send_cmd(CMD_RSVD_LO + 3'd1, 16'hFFFF, 4'd15, 1'b1);
    send_cmd(CMD_RSVD_HI, 16'd0, 4'd0, 1'b0);
    send_cmd(CMD_CLEAR, 16'd0, 4'd0, 1'b0);
    send_cmd(CMD_RELEASE, 16'd0, 4'd0, 1'b0);      // ring empty, ignored
    send_cmd(CMD_ACQUIRE, 16'd4, 4'd0, 1'b0);      // no open segment, one opens
    send_cmd(CMD_RELEASE, 16'd0, 4'd0, 1'b0);      // frees the open segment itself
    send_cmd(CMD_POP, 16'd0, 4'd0, 1'b1);
    send_cmd(CMD_ACQUIRE, 16'hFFFF, 4'd15, 1'b1);  // padded size wraps, refused

    for (int ph = 0; ph < PHASES; ph++) begin
      cmd_valid <= 1'b0;
      drain();
      write_reg(CFG_MAX_PACKET, MAX_TAB[ph]);
      write_reg(CFG_SEG_CAPACITY, CAP_TAB[ph]);
      cfg_valid <= 1'b0;
      cur_max = MAX_TAB[ph];
      cur_cap = CAP_TAB[ph];
      if (ph < 3) begin
        send_idle <= 6;
        recv_idle <= 88;
      end else if (ph < 6) begin
        send_idle <= 88;
        recv_idle <= 6;
      end else begin
        send_idle <= 0;
        recv_idle <= 0;
      end
      lim = (cur_max < cur_cap - 4) ? cur_max : cur_cap - 4;
      small_lim = (lim < 64) ? lim : 64;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // hold off until every result is back once per phase
        if (n == PHASE_ITEMS / 2) begin
          cmd_valid <= 1'b0;
          drain();
        end
        pkt = 16'($urandom);
        sid = 4'($urandom);
        fl  = 1'($urandom);
        w = $urandom_range(99);
        if (w < 40) begin
          c = CMD_ACQUIRE;
          r = $urandom_range(99);
          if (r < 5)
            pkt = '0;
          else if (r < 10)
            pkt = cur_max;
          else if (r < 14)
            pkt = cur_max + 16'd1;
          else if (r < 22)
            pkt = 16'($urandom);
          else if (r < 65)
            pkt = 16'($urandom_range(small_lim, 1));
          else
            pkt = 16'($urandom_range(lim, 1));
        end else if (w < 65) begin
          c = CMD_COMMIT;
          if ($urandom_range(3) != 0)
            sid = commit_hint;
          fl = ($urandom_range(9) < 3);
        end else if (w < 80) begin
          c = CMD_POP;
        end else if (w < 92) begin
          c = CMD_RELEASE;
        end else if (w < 94) begin
          c = CMD_CLEAR;
        end else begin
          c = 3'($urandom_range(CMD_RSVD_HI, CMD_RSVD_LO));
        end
        send_cmd(c, pkt, sid, fl);
      end
    end

    cmd_valid <= 1'b0;
    drain();
    repeat (16) @(posedge clk);
    if (fail_count == 0 && waiting == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
